// File: sv/key_ecc_check_bits_top_assert.svh
// Assertion macros for the key check-bit block.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef KEY_ECC_CHECK_BITS_TOP_ASSERT_SVH
`define KEY_ECC_CHECK_BITS_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define KECC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define KECC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kecc_pkg.sv
// Shared constants and types for the key check-bit block.
// No dependencies.
`default_nettype none

package kecc_pkg;

    localparam int KEY_BITS    = 128;
    localparam int HALF_BITS   = 64;
    localparam int DATA_BITS   = 106;
    localparam int CHECK_BITS  = 21;
    localparam int ACC_BITS    = 24;
    localparam int WEIGHT_BITS = 7;
    localparam int CELL_BITS   = 8;
    localparam int NUM_CELLS   = (DATA_BITS + CELL_BITS - 1) / CELL_BITS;
    localparam int OUT_BITS    = 136;

    localparam logic [ACC_BITS-1:0]    ECC_POLY      = 24'h360325;
    localparam logic [WEIGHT_BITS-1:0] WANTED_WEIGHT = 7'd53;

    typedef struct packed {
        logic [ACC_BITS-1:0]    acc;
        logic                   par;
        logic [WEIGHT_BITS-1:0] weight;
    } cell_state_t;

endpackage

`default_nettype wire

// File: sv/kecc_cell.sv
// One cell of the check-bit chain: folds up to CELL_BITS data bits into the
// accumulator, parity and weight, then registers them. Depends on kecc_pkg.
`default_nettype none

module kecc_cell #(
    parameter int FIRST_BIT = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          in_valid,
    input  wire logic [kecc_pkg::KEY_BITS-1:0] in_key,
    input  wire kecc_pkg::cell_state_t         in_st,
    output logic                               out_valid,
    output logic [kecc_pkg::KEY_BITS-1:0]      out_key,
    output kecc_pkg::cell_state_t              out_st
);
    import kecc_pkg::*;

    localparam int NB = (FIRST_BIT + CELL_BITS > DATA_BITS) ? (DATA_BITS - FIRST_BIT)
                                                             : CELL_BITS;

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    cell_state_t           st_reg;
    cell_state_t           st_next;

    always_comb
    begin
        logic [ACC_BITS-1:0]    acc;
        logic                   par;
        logic [WEIGHT_BITS-1:0] w;
        logic                   b;
        acc = in_st.acc;
        par = in_st.par;
        w   = in_st.weight;
        for (int i = 0; i < NB; i++)
        begin
            b      = in_key[FIRST_BIT + i];
            acc[0] = acc[0] ^ b;
            if (acc[0])
            begin
                acc = acc ^ ECC_POLY;
            end
            acc = acc >> 1;
            par = par ^ b;
            w   = w + {{(WEIGHT_BITS-1){1'b0}}, b};
        end
        st_next.acc    = acc;
        st_next.par    = par;
        st_next.weight = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= in_key;
            st_reg  <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_st    = st_reg;

endmodule

`default_nettype wire

// File: sv/kecc_final.sv
// Output stage: places check and parity bits, compares with the input key,
// checks the weight and holds the word for the sink. Depends on kecc_pkg.
`default_nettype none

module kecc_final (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [kecc_pkg::KEY_BITS-1:0] in_key,
    input  wire kecc_pkg::cell_state_t         in_st,
    output logic                               advance,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [kecc_pkg::OUT_BITS-1:0]      out_data
);
    import kecc_pkg::*;

    localparam int KEEP_HI = DATA_BITS - HALF_BITS;

    logic                  valid_reg;
    logic [OUT_BITS-1:0]   data_reg;
    logic [OUT_BITS-1:0]   data_next;
    logic [HALF_BITS-1:0]  coded_high;
    logic                  par_final;

    always_comb
    begin
        par_final  = in_st.par ^ (^in_st.acc[CHECK_BITS-1:0]);
        coded_high = {par_final, in_st.acc[CHECK_BITS-1:0], in_key[DATA_BITS-1:HALF_BITS]};
        data_next  = {6'b0,
                      (in_st.weight == WANTED_WEIGHT),
                      (coded_high == in_key[KEY_BITS-1:HALF_BITS]),
                      coded_high,
                      in_key[HALF_BITS-1:0]};
    end

    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    if (KEEP_HI + CHECK_BITS + 1 != HALF_BITS)
    begin : g_bad_layout
        $error("coded_high layout mismatch");
    end

endmodule

`default_nettype wire

// File: sv/key_ecc_check_bits_top.sv
// Top level of the key check-bit block: a chain of kecc_cell stages and the
// kecc_final output stage. Depends on kecc_pkg, kecc_cell, kecc_final.
//
//   channel   dir  word bits  contents
//   s_axis    in   128        key_low, key_high
//   m_axis    out  136        coded_low, coded_high, code_matches, weight_ok
//
// One word enters per cycle while m_axis is not stalled; each word passes through
// the 14 cells (8 data bits each, 2 in the last) and then the output register.
// Reset clears only the valid bits of the cells and the output register.
// A stall on m_axis freezes the whole chain; s_axis_tready follows at once.
`default_nettype none

module key_ecc_check_bits_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // key_low[63:0], key_high[127:64]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata   // coded_low[63:0], coded_high[127:64],
                                             // code_matches[128], weight_ok[129], zeros
);
    import kecc_pkg::*;

    logic                valid_chain [NUM_CELLS+1];
    logic [KEY_BITS-1:0] key_chain   [NUM_CELLS+1];
    cell_state_t         st_chain    [NUM_CELLS+1];
    logic                advance;

    assign valid_chain[0] = s_axis_tvalid;
    assign key_chain[0]   = s_axis_tdata;
    assign st_chain[0]    = '0;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        kecc_cell #(
            .FIRST_BIT (g * CELL_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_chain[g]),
            .in_key    (key_chain[g]),
            .in_st     (st_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_key   (key_chain[g+1]),
            .out_st    (st_chain[g+1])
        );
    end

    kecc_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_chain[NUM_CELLS]),
        .in_key    (key_chain[NUM_CELLS]),
        .in_st     (st_chain[NUM_CELLS]),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    assign s_axis_tready = advance;

endmodule

`default_nettype wire

// File: sv/kecc_checker.sv
// Port checker for key_ecc_check_bits_top, bound to the top level.
// Depends on key_ecc_check_bits_top_assert.svh.
`default_nettype none

module kecc_port_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata
);
`include "key_ecc_check_bits_top_assert.svh"

    `KECC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")
    `KECC_ASSERT_NOW(a_parity, m_axis_tvalid, m_axis_tdata[127] == (^m_axis_tdata[126:0]), "parity bit disagrees with coded key")
    `KECC_ASSERT_NOW(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not track output stage")
    `KECC_ASSERT_NOW(a_pad, m_axis_tvalid, m_axis_tdata[135:130] == 6'b0, "pad bits set in output word")

endmodule

bind key_ecc_check_bits_top kecc_port_checker u_kecc_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: dv/kecc_checker.sv
`timescale 1ns / 1ps
// Check-bit encoder used by the testbench, and the port checker of key_ecc_check_bits_top.
// The checker predicts each output word from the accepted key and compares them.
// Depends on kecc_pkg.

package kecc_tb_pkg;
    import kecc_pkg::*;

    function automatic logic [KEY_BITS-1:0] ecc_encode(input logic [KEY_BITS-1:0] key);
        logic [ACC_BITS-1:0] acc;
        logic                par;
        logic [KEY_BITS-1:0] coded;
        acc   = '0;
        par   = 1'b0;
        coded = '0;
        coded[DATA_BITS-1:0] = key[DATA_BITS-1:0];
        for (int n = 0; n < DATA_BITS; n++)
        begin
            acc[0] = acc[0] ^ key[n];
            if (acc[0])
                acc = acc ^ ECC_POLY;
            par = par ^ key[n];
            acc = acc >> 1;
        end
        for (int n = DATA_BITS; n < KEY_BITS - 1; n++)
        begin
            coded[n] = acc[0];
            par      = par ^ acc[0];
            acc      = acc >> 1;
        end
        coded[KEY_BITS-1] = par;
        return coded;
    endfunction

endpackage

module kecc_checker
    import kecc_pkg::*, kecc_tb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // key_low[63:0], key_high[127:64]
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [135:0] m_axis_tdata,   // coded_low, coded_high, code_matches,
                                              // weight_ok, zeros
    output int                errors,
    output int                pending,
    output int                words_checked,
    output int                code_hits,
    output int                weight_hits
);

    typedef struct {
        logic [63:0] coded_low;
        logic [63:0] coded_high;
        logic        code_matches;
        logic        weight_ok;
    } key_check_t;

    key_check_t expected_codes[$];

    initial
    begin
        errors        = 0;
        pending       = 0;
        words_checked = 0;
        code_hits     = 0;
        weight_hits   = 0;
    end

    always @(posedge clk)
    begin
        key_check_t          want;
        key_check_t          got;
        logic [KEY_BITS-1:0] coded;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            coded             = ecc_encode(s_axis_tdata);
            want.coded_low    = coded[63:0];
            want.coded_high   = coded[127:64];
            want.code_matches = (coded == s_axis_tdata);
            want.weight_ok    = ($countones(s_axis_tdata[DATA_BITS-1:0]) == WANTED_WEIGHT);
            expected_codes.push_back(want);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.coded_low    = m_axis_tdata[63:0];
            got.coded_high   = m_axis_tdata[127:64];
            got.code_matches = m_axis_tdata[128];
            got.weight_ok    = m_axis_tdata[129];
            if (expected_codes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected output word %h", $realtime, m_axis_tdata);
            end
            else
            begin
                want = expected_codes.pop_front();
                words_checked++;
                code_hits   += want.code_matches;
                weight_hits += want.weight_ok;
                if (got.coded_low !== want.coded_low || got.coded_high !== want.coded_high
                    || got.code_matches !== want.code_matches
                    || got.weight_ok !== want.weight_ok || m_axis_tdata[135:130] !== '0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: word %0d mismatch", $realtime, words_checked - 1);
                        $display("  expected low %h high %h matches %b weight_ok %b pad 0",
                                 want.coded_low, want.coded_high, want.code_matches,
                                 want.weight_ok);
                        $display("  actual   low %h high %h matches %b weight_ok %b pad %h",
                                 got.coded_low, got.coded_high, got.code_matches,
                                 got.weight_ok, m_axis_tdata[135:130]);
                    end
                end
            end
        end
        pending = expected_codes.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for key_ecc_check_bits_top: drives keys in random bursts, stalls the output
// side on its own pattern, and reports the verdict. Depends on kecc_pkg, kecc_tb_pkg,
// kecc_checker and the block itself.

module tb;
    import kecc_pkg::*, kecc_tb_pkg::*;

    localparam int                  RANDOM_WORDS = 700;
    localparam int                  IDLE_LIMIT   = 2000;
    localparam int                  DRAIN_CYCLES = NUM_CELLS + 6;
    localparam logic [KEY_BITS-1:0] DATA_MASK    = (128'b1 << DATA_BITS) - 1;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;

    int errors;
    int pending;
    int words_checked;
    int code_hits;
    int weight_hits;
    int burst_left  = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    key_ecc_check_bits_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kecc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked),
        .code_hits     (code_hits),
        .weight_hits   (weight_hits)
    );

    function automatic logic [KEY_BITS-1:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // data bits with exactly the given number of ones, check field random
    function automatic logic [KEY_BITS-1:0] weighted_key(input int ones);
        logic [KEY_BITS-1:0] key;
        int                  count;
        int                  pos;
        key   = random_key() & ~DATA_MASK;
        count = 0;
        while (count < ones)
        begin
            pos = $urandom_range(0, DATA_BITS - 1);
            if (!key[pos])
            begin
                key[pos] = 1'b1;
                count++;
            end
        end
        return key;
    endfunction

    task automatic send_word(input logic [KEY_BITS-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= random_key();
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("FAIL key_ecc_check_bits_top");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_BITS-1:0] stripes;
        logic [KEY_BITS-1:0] key;
        int                  pick;
        stripes = {4{32'h5555_5555}};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word('0);
        send_word('1);
        send_word(ecc_encode('1));
        send_word(128'b1 << 127);
        send_word(128'b1 << DATA_BITS);
        send_word(128'b1 << (DATA_BITS - 1));
        send_word(128'b1);
        send_word(ecc_encode(128'b1));
        send_word(ecc_encode(128'b1 << (DATA_BITS - 1)));
        send_word((128'b1 << 53) - 1);
        send_word(((128'b1 << 53) - 1) << 53);
        send_word((128'b1 << 52) - 1);
        send_word((128'b1 << 54) - 1);
        send_word(ecc_encode((128'b1 << 53) - 1));
        send_word(ecc_encode(stripes) ^ (128'b1 << 127));
        send_word(ecc_encode(stripes) ^ (128'b1 << 110));
        send_word(ecc_encode(stripes) ^ (128'b1 << 64));
        send_word(stripes);
        send_word(~stripes);
        send_word(ecc_encode(~stripes));
        send_word(~ecc_encode('0));
        send_word({64'h0, 64'hFFFF_FFFF_FFFF_FFFF});

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                key = ecc_encode(random_key());
            else if (pick < 50)
                key = ecc_encode(weighted_key(53));
            else if (pick < 65)
                key = ecc_encode(random_key()) ^ (128'b1 << $urandom_range(0, KEY_BITS - 1));
            else if (pick < 75)
                key = weighted_key($urandom_range(52, 54));
            else if (pick < 85)
            begin
                key = weighted_key($urandom_range(0, DATA_BITS));
                if ($urandom_range(0, 1))
                    key = ecc_encode(key);
            end
            else
                key = random_key();
            send_word(key);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d keys: %0d carried consistent check bits, %0d had 53 data ones",
                 words_checked, code_hits, weight_hits);
        $display("output stalls and input gaps were mixed with full-rate stretches");
        if (errors == 0)
            $display("PASS key_ecc_check_bits_top");
        else
            $display("FAIL key_ecc_check_bits_top");
        $finish;
    end

endmodule
